// File: design/lpfr_pkg.sv
// Package for the length-prefixed frame receiver.
// Holds the shared constants, the config struct and the result struct.
// No dependencies.
package lpfr_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int SEEN_W    = 16;
  localparam int IDX_W     = 10;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [7:0] PING_RESET  = 8'h52;
  localparam logic [7:0] START_RESET = 8'h02;

  localparam logic REG_PING  = 1'b0;
  localparam logic REG_START = 1'b1;

  typedef struct packed {
    logic [7:0] ping_char;
    logic [7:0] start_char;
  } cfg_t;

  typedef struct packed {
    logic             echo_ping;
    logic [7:0]       forward_byte;
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic             payload_overflow;
    logic [7:0]       frame_type;
    logic [15:0]      frame_length;
    logic             frame_done;
    logic             holding;
  } result_t;

endpackage

// File: design/length_prefixed_frame_receiver_top.sv
// Length-prefixed frame receiver, top level.
// Instantiates lpfr_cfg_regs, lpfr_parser and lpfr_out_reg; uses lpfr_pkg.
//
// Input channel: one host byte per item on rx_byte (in_valid / in_stall).
// Output channel: one result per input byte (out_valid / out_stall) with the
// echo flag, the forwarded byte, payload byte/index/overflow, the frame's
// type and length, the frame-done flag and the hold flag.
// Config: APB port, ping_char at 0x0, start_char at 0x4; pready is tied high.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one item per cycle while in_stall is low; the phase update and
// the result are computed combinationally from the input byte.
// When the receiver stalls, the result register holds and in_stall rises
// in the same cycle, so no byte is taken until the result leaves.
// Reset (synchronous, active high): phase goes idle, held type, length and
// position clear, ping_char returns to 'R' and start_char to 0x02.
module length_prefixed_frame_receiver_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         echo_ping,
  output logic [7:0]                   forward_byte,
  output logic                         payload_valid,
  output logic [7:0]                   payload_byte,
  output logic [lpfr_pkg::IDX_W-1:0]   payload_index,
  output logic                         payload_overflow,
  output logic [7:0]                   frame_type,
  output logic [15:0]                  frame_length,
  output logic                         frame_done,
  output logic                         holding,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0] paddr,
  input  logic [lpfr_pkg::PDATA_W-1:0] pwdata,
  output logic [lpfr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  lpfr_pkg::cfg_t    cfg;
  lpfr_pkg::result_t res;
  lpfr_pkg::result_t res_q;
  logic              accept;
  logic              busy;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  lpfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  lpfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .busy      (busy)
  );

  assign echo_ping        = res_q.echo_ping;
  assign forward_byte     = res_q.forward_byte;
  assign payload_valid    = res_q.payload_valid;
  assign payload_byte     = res_q.payload_byte;
  assign payload_index    = res_q.payload_index;
  assign payload_overflow = res_q.payload_overflow;
  assign frame_type       = res_q.frame_type;
  assign frame_length     = res_q.frame_length;
  assign frame_done       = res_q.frame_done;
  assign holding          = res_q.holding;

endmodule

// File: design/lpfr_cfg_regs.sv
// APB register block for ping_char and start_char.
// Depends on lpfr_pkg.
module lpfr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0] paddr,
  input  logic [lpfr_pkg::PDATA_W-1:0] pwdata,
  output logic [lpfr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output lpfr_pkg::cfg_t               cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_char  <= lpfr_pkg::PING_RESET;
      cfg.start_char <= lpfr_pkg::START_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        lpfr_pkg::REG_PING:  cfg.ping_char  <= pwdata[7:0];
        lpfr_pkg::REG_START: cfg.start_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lpfr_pkg::REG_PING:  prdata = {24'h0, cfg.ping_char};
      lpfr_pkg::REG_START: prdata = {24'h0, cfg.start_char};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: design/lpfr_parser.sv
// Frame parser: phase sequencer, held type/length and payload position.
// Computes one result per accepted byte. Depends on lpfr_pkg.
module lpfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  lpfr_pkg::cfg_t    cfg,
  output lpfr_pkg::result_t res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;
  localparam logic [2:0] PH_HOLD   = 3'd6;

  localparam logic [lpfr_pkg::SEEN_W:0] DEPTH_W = (lpfr_pkg::SEEN_W+1)'(lpfr_pkg::BUF_DEPTH);

  logic [2:0]                  phase, phase_next;
  logic [7:0]                  held_type, held_type_next;
  logic [15:0]                 held_length, held_length_next;
  logic [lpfr_pkg::SEEN_W-1:0] bytes_seen, bytes_seen_next;
  logic [lpfr_pkg::SEEN_W-1:0] seen_inc;

  assign seen_inc = bytes_seen + 1'b1;

  always_comb begin
    phase_next       = phase;
    held_type_next   = held_type;
    held_length_next = held_length;
    bytes_seen_next  = bytes_seen;
    res              = '0;
    res.forward_byte = rx_byte;
    case (phase)
      PH_IDLE: begin
        if (rx_byte == cfg.ping_char) begin
          res.echo_ping = 1'b1;
        end else if (rx_byte == cfg.start_char) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_next = rx_byte;
        phase_next     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length_next = {8'h00, rx_byte};
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_length_next = {held_length[7:0], rx_byte};
        bytes_seen_next  = '0;
        phase_next       = ({held_length[7:0], rx_byte} == 16'h0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        res.payload_valid    = 1'b1;
        res.payload_byte     = rx_byte;
        res.payload_index    = bytes_seen[lpfr_pkg::IDX_W-1:0];
        res.payload_overflow = ({1'b0, bytes_seen} >= DEPTH_W);
        bytes_seen_next      = seen_inc;
        if (seen_inc == held_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res.frame_done = 1'b1;
        phase_next     = PH_HOLD;
      end
      default: begin
        // hold, and the unused code behaves the same
        if (rx_byte == cfg.ping_char) begin
          res.echo_ping = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
    endcase
    res.frame_type   = held_type_next;
    res.frame_length = held_length_next;
    res.holding      = (phase_next >= PH_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      held_type   <= '0;
      held_length <= '0;
      bytes_seen  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

  a_check_to_hold: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CHECK |=> phase == PH_HOLD)
    else $error("checksum byte did not enter hold");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_LEN_LO && held_length[7:0] == 8'h00 && rx_byte == 8'h00
    |=> phase == PH_CHECK)
    else $error("zero length frame did not skip to checksum");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(bytes_seen) && $stable(held_length))
    else $error("state changed without an accepted item");

  a_data_seen: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DATA |=> bytes_seen == $past(bytes_seen) + 1'b1)
    else $error("payload position did not advance");

endmodule

// File: design/lpfr_out_reg.sv
// Result register with valid/stall handshake on the output side.
// Depends on lpfr_pkg.
module lpfr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lpfr_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output lpfr_pkg::result_t res_q,
  output logic              busy
);

  logic out_valid_next;

  assign busy = out_valid && out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule
